/* rtl/ttb_pkg.sv */
// Types, constants and character maps for the text-to-bytes decoder.
// No dependencies; every other file imports this package.
`default_nettype none
package ttb_pkg;

	localparam logic [1:0] MODE_ASCII  = 2'd0;
	localparam logic [1:0] MODE_HEX    = 2'd1;
	localparam logic [1:0] MODE_B64    = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] HEX_ADJ   = 8'd9;
	localparam logic [3:0] NIB_MASK  = 4'hF;
	localparam logic [7:0] CHAR_PAD  = 8'h3D;
	localparam logic [7:0] B64_BAD   = 8'hFF;

	typedef struct packed {
		logic [7:0] char_code;
		logic       first_char;
		logic       odd_length;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       bad_char;
		logic       end_of_string;
	} out_item_t;

	typedef struct packed {
		logic [1:0] group_phase;
		logic [7:0] held_value;
		logic       bad_pending;
	} dec_state_t;

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] a;
		a = (c > CHAR_NINE) ? (c + HEX_ADJ) : c;
		return a[3:0] & NIB_MASK;
	endfunction

	function automatic logic [7:0] b64_index(input logic [7:0] c);
		logic [7:0] v;
		v = B64_BAD;
		if (c inside {[8'h41:8'h5A]}) begin
			v = c - 8'h41;
		end else if (c inside {[8'h61:8'h7A]}) begin
			v = c - 8'h61 + 8'd26;
		end else if (c inside {[8'h30:8'h39]}) begin
			v = c - 8'h30 + 8'd52;
		end else if (c == 8'h2B) begin
			v = 8'd62;
		end else if (c == 8'h2F) begin
			v = 8'd63;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

/* rtl/ttb_decode.sv */
// Single-step decode: one character and the grouping state in, next state
// and an optional byte out. Combinational; depends on ttb_pkg.
`default_nettype none
module ttb_decode (
	input  wire logic [1:0]         mode,
	input  wire ttb_pkg::in_item_t  item,
	input  wire ttb_pkg::dec_state_t cur,
	output ttb_pkg::dec_state_t     nxt,
	output logic                    emit,
	output ttb_pkg::out_item_t      result
);
	import ttb_pkg::*;

	logic [3:0] nib;
	logic [7:0] v;
	logic       vbad;
	logic [7:0] byte_v;
	logic       bad_v;
	dec_state_t st;

	always_comb begin
		nib    = hex_nibble(item.char_code);
		v      = b64_index(item.char_code);
		vbad   = (v == B64_BAD);
		st     = item.first_char ? '0 : cur;
		emit   = 1'b0;
		byte_v = '0;
		bad_v  = 1'b0;
		case (mode)
			MODE_ASCII: begin
				emit   = 1'b1;
				byte_v = item.char_code;
			end
			MODE_HEX: begin
				if (item.first_char && item.odd_length) begin
					emit           = 1'b1;
					byte_v         = {4'd0, nib};
					st.group_phase = 2'd0;
				end else if (st.group_phase != 2'd0) begin
					emit           = 1'b1;
					byte_v         = {st.held_value[3:0], nib};
					st.group_phase = 2'd0;
				end else if (item.last_char) begin
					emit   = 1'b1;
					byte_v = {nib, 4'd0};
				end else begin
					st.held_value  = {4'd0, nib};
					st.group_phase = 2'd1;
				end
			end
			MODE_B64: begin
				if (item.char_code != CHAR_PAD) begin
					case (st.group_phase)
						2'd0: begin
							st.bad_pending = vbad;
						end
						2'd1: begin
							emit   = 1'b1;
							byte_v = {st.held_value[5:0], 2'd0} + {4'd0, v[7:4]};
						end
						2'd2: begin
							emit   = 1'b1;
							byte_v = {st.held_value[3:0], 4'd0} + {2'd0, v[7:2]};
						end
						default: begin
							emit   = 1'b1;
							byte_v = {st.held_value[1:0], 6'd0} + v;
						end
					endcase
					if (emit) begin
						bad_v          = st.bad_pending | vbad;
						st.bad_pending = vbad;
					end
					st.held_value  = v;
					st.group_phase = st.group_phase + 2'd1;
				end
				if (item.last_char && !emit && st.group_phase == 2'd1) begin
					emit   = 1'b1;
					byte_v = {st.held_value[5:0], 2'd0};
					bad_v  = st.bad_pending;
				end
			end
			default: begin
				st = cur;
			end
		endcase
		if (item.last_char && mode != MODE_UNUSED) begin
			st = '0;
		end
		nxt                  = st;
		result.byte_out      = byte_v;
		result.bad_char      = bad_v;
		result.end_of_string = item.last_char;
	end

endmodule
`default_nettype wire

/* rtl/text_to_bytes_decoder_core.sv */
// Text-to-bytes decoder top level: input register, decode step, result register.
// Depends on ttb_pkg and ttb_decode.
//
// channel | signals                      | payload
// src     | src_valid / src_ready        | ttb_pkg::in_item_t  (one character)
// dst     | dst_valid / dst_ready        | ttb_pkg::out_item_t (zero or one byte)
// cfg     | cfg_we                       | cfg_wdata, decode mode
//
// One request a cycle while the result is not stalled; a byte is offered from the
// result register. The grouping state is read and written once per step.
// Reset clears the mode, the grouping state and both valid flags.
// A stalled result holds the input register; src_ready stays high while the
// input register is empty or moving.
`default_nettype none
module text_to_bytes_decoder_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               src_valid,
	output logic                    src_ready,
	input  wire ttb_pkg::in_item_t  src_data,
	output logic                    dst_valid,
	input  wire logic               dst_ready,
	output ttb_pkg::out_item_t      dst_data,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_wdata
);
	import ttb_pkg::*;

	logic       b64_mode;
	logic [1:0] decode_mode_q;
	logic       valid_s1;
	in_item_t   item_s1;
	dec_state_t state_q;
	dec_state_t state_nxt;
	logic       emit;
	out_item_t  result;
	logic       dst_valid_q;
	out_item_t  dst_data_q;
	logic       advance;

	assign b64_mode  = (decode_mode_q == MODE_B64);
	assign advance   = valid_s1 && (!dst_valid_q || dst_ready);
	assign src_ready = !valid_s1 || advance;
	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_data_q;

	ttb_decode u_decode (
		.mode   (decode_mode_q),
		.item   (item_s1),
		.cur    (state_q),
		.nxt    (state_nxt),
		.emit   (emit),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= MODE_ASCII;
		end else if (cfg_we) begin
			decode_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			item_s1 <= src_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (advance) begin
			dst_valid_q <= emit;
		end else if (dst_ready) begin
			dst_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			dst_data_q <= result;
		end
	end

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!src_ready |-> (valid_s1 && dst_valid_q && !dst_ready))
		else $error("input stalled without a blocked result");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.last_char && decode_mode_q != MODE_UNUSED)
		|=> (state_q.group_phase == 2'd0 && !state_q.bad_pending))
		else $error("grouping not cleared after last character");

	a_bad_b64: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid_q && dst_data_q.bad_char) |-> b64_mode)
		else $error("bad character flagged outside base64 mode");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(state_q)))
		else $error("state moved while step was stalled");

endmodule
`default_nettype wire
